### rtl/core/binary_to_decimal_digits_unit_assert.svh
// assertion macros shared by the converter and the digit sequencer
// no dependencies; include once per file that asserts
`ifndef BINARY_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH

// checked at every edge outside reset
`define B2D_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("b2d assertion failed");

// checked at every edge, reset included
`define B2D_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("b2d assertion failed");

`endif

### rtl/core/b2d_pkg.sv
// shared constants, types and helper functions of the binary to decimal digit unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b2d_pkg;

   localparam int VALUE_WIDTH    = 27;
   localparam int ROW_WIDTH      = 3;
   localparam int DIGIT_WIDTH    = 4;
   localparam int COLUMN_WIDTH   = 7;
   localparam int DIGITS_DEFAULT = 8;

   // places that get an extra gap in front of them
   localparam int GAP_PLACE_HI = 5;
   localparam int GAP_PLACE_LO = 2;

   localparam logic [DIGIT_WIDTH-1:0]  BLANK_CODE   = 4'd10;
   localparam logic [DIGIT_WIDTH-1:0]  ZERO_DIGIT   = 4'd0;
   localparam logic [DIGIT_WIDTH-1:0]  ADJUST_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0]  ADJUST_ADD   = 4'd3;
   localparam logic [COLUMN_WIDTH-1:0] CELL_WIDTH   = 7'd10;
   localparam logic [COLUMN_WIDTH-1:0] GROUP_GAP    = 7'd2;
   localparam logic [COLUMN_WIDTH-1:0] NO_GAP       = 7'd0;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_SHIFT,
      CONV_DONE
   } conv_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_RUN,
      EMIT_ZERO
   } emit_state_type;

   function automatic longint unsigned pow10(input int e);
      longint unsigned w;
      w = 64'd1;
      for (int i = 0; i < e; i++) begin
         w = w * 64'd10;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/core/b2d_req_if.sv
// input channel: value and display row with valid/ready
// depends on b2d_pkg
`timescale 1ns / 1ps
`default_nettype none

interface b2d_req_if;
   logic                             valid;
   logic                             ready;
   logic [b2d_pkg::VALUE_WIDTH-1:0] value;
   logic [b2d_pkg::ROW_WIDTH-1:0]   row;

   modport source (output valid, output value, output row, input ready);
   modport sink   (input valid, input value, input row, output ready);
endinterface

`default_nettype wire

### rtl/core/b2d_rsp_if.sv
// result channel: one digit cell per beat with valid/ready
// depends on b2d_pkg
`timescale 1ns / 1ps
`default_nettype none

interface b2d_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [b2d_pkg::DIGIT_WIDTH-1:0]  digit;
   logic [b2d_pkg::COLUMN_WIDTH-1:0] column;
   logic [b2d_pkg::ROW_WIDTH-1:0]    out_row;
   logic                              last;

   modport source (output valid, output digit, output column, output out_row,
                   output last, input ready);
   modport sink   (input valid, input digit, input column, input out_row,
                   input last, output ready);
endinterface

`default_nettype wire

### rtl/core/b2d_convert.sv
// bit-serial binary to bcd converter (shift and add-3), one input bit per cycle
// depends on b2d_pkg, b2d_req_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_digits_unit_assert.svh"

module b2d_convert #(
   parameter int DIGITS = b2d_pkg::DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   b2d_req_if.sink                               req_bus,
   output logic                                  bcd_valid,
   input  logic                                  bcd_ready,
   output logic [DIGITS*b2d_pkg::DIGIT_WIDTH-1:0] bcd_data,
   output logic [b2d_pkg::ROW_WIDTH-1:0]         bcd_row
);

   localparam int BCD_W = DIGITS * b2d_pkg::DIGIT_WIDTH;
   localparam int VAL_W = b2d_pkg::VALUE_WIDTH;
   localparam int CNT_W = $clog2(VAL_W + 1);
   localparam logic [63:0] MAX_VALUE = 64'(b2d_pkg::pow10(DIGITS)) - 64'd1;

   b2d_pkg::conv_state_type state_ff, state_in;
   logic [VAL_W-1:0]                 bin_ff, bin_in;
   logic [BCD_W-1:0]                 bcd_ff, bcd_in;
   logic [BCD_W-1:0]                 bcd_adj;
   logic [b2d_pkg::ROW_WIDTH-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [VAL_W-1:0]                 value_sat;
   logic                             req_fire;
   logic                             hand_fire;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign hand_fire = bcd_valid && bcd_ready;

   // clamp to the largest value the display can show
   assign value_sat = (64'(req_bus.value) > MAX_VALUE) ? MAX_VALUE[VAL_W-1:0]
                                                        : req_bus.value;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         b2d_pkg::CONV_IDLE: begin
            if (req_fire) state_in = b2d_pkg::CONV_SHIFT;
         end
         b2d_pkg::CONV_SHIFT: begin
            if (cnt_ff == CNT_W'(1)) state_in = b2d_pkg::CONV_DONE;
         end
         b2d_pkg::CONV_DONE: begin
            if (hand_fire) state_in = b2d_pkg::CONV_IDLE;
         end
         default: state_in = b2d_pkg::CONV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready = (state_ff == b2d_pkg::CONV_IDLE);
      bcd_valid     = (state_ff == b2d_pkg::CONV_DONE);
      bcd_data      = bcd_ff;
      bcd_row       = row_ff;
   end

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      logic [b2d_pkg::DIGIT_WIDTH-1:0] d;
      d = '0;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[i*b2d_pkg::DIGIT_WIDTH +: b2d_pkg::DIGIT_WIDTH];
         bcd_adj[i*b2d_pkg::DIGIT_WIDTH +: b2d_pkg::DIGIT_WIDTH] =
            (d >= b2d_pkg::ADJUST_LIMIT) ? d + b2d_pkg::ADJUST_ADD : d;
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (req_fire) begin
         bin_in = value_sat;
         bcd_in = '0;
         row_in = req_bus.row;
         cnt_in = CNT_W'(VAL_W);
      end else if (state_ff == b2d_pkg::CONV_SHIFT) begin
         bin_in = {bin_ff[VAL_W-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VAL_W-1]};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2d_pkg::CONV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      row_ff <= row_in;
   end

   `B2D_ASSERT(a_accept_starts_shift, clock, reset, req_fire |=> state_ff == b2d_pkg::CONV_SHIFT)
   `B2D_ASSERT(a_done_count_empty, clock, reset, bcd_valid |-> cnt_ff == '0)
   `B2D_ASSERT(a_handoff_frees, clock, reset, hand_fire |=> req_bus.ready)

endmodule

`default_nettype wire

### rtl/core/b2d_emit.sv
// digit sequencer: shifts bcd digits out one per beat, blanks leading zeros,
// tracks the pixel column; depends on b2d_pkg, b2d_rsp_if and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_digits_unit_assert.svh"

module b2d_emit #(
   parameter int DIGITS = b2d_pkg::DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  bcd_valid,
   output logic                                  bcd_ready,
   input  logic [DIGITS*b2d_pkg::DIGIT_WIDTH-1:0] bcd_data,
   input  logic [b2d_pkg::ROW_WIDTH-1:0]         bcd_row,
   b2d_rsp_if.source                             rsp_bus
);

   localparam int DW    = b2d_pkg::DIGIT_WIDTH;
   localparam int CW    = b2d_pkg::COLUMN_WIDTH;
   localparam int RW    = b2d_pkg::ROW_WIDTH;
   localparam int BCD_W = DIGITS * DW;
   localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   b2d_pkg::emit_state_type state_ff, state_in;
   logic [BCD_W-1:0] digits_ff, digits_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             started_ff, started_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [CW-1:0]    lastcol_ff, lastcol_in;
   logic             out_valid_ff, out_valid_in;
   logic [DW-1:0]    out_digit_ff, out_digit_in;
   logic [CW-1:0]    out_col_ff, out_col_in;
   logic [RW-1:0]    out_row_ff, out_row_in;
   logic             out_last_ff, out_last_in;

   logic [DW-1:0] top_digit;
   logic          gap;
   logic [CW-1:0] col_use;
   logic          started_now;
   logic          at_end;
   logic          load;
   logic          adv;
   logic          in_zero;
   logic          zero_out;

   assign top_digit   = digits_ff[BCD_W-1 -: DW];
   assign gap         = (int'(pos_ff) == DIGITS - 1 - b2d_pkg::GAP_PLACE_HI) ||
                        (int'(pos_ff) == DIGITS - 1 - b2d_pkg::GAP_PLACE_LO);
   assign col_use     = col_ff + (gap ? b2d_pkg::GROUP_GAP : b2d_pkg::NO_GAP);
   assign started_now = started_ff || (top_digit != b2d_pkg::ZERO_DIGIT);
   assign at_end      = (pos_ff == POS_W'(DIGITS - 1));
   assign in_zero     = (state_ff == b2d_pkg::EMIT_ZERO);
   assign zero_out    = out_valid_ff && out_last_ff && (out_digit_ff == b2d_pkg::ZERO_DIGIT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         b2d_pkg::EMIT_IDLE: begin
            if (load) state_in = b2d_pkg::EMIT_RUN;
         end
         b2d_pkg::EMIT_RUN: begin
            if (adv && at_end) begin
               state_in = started_now ? b2d_pkg::EMIT_IDLE : b2d_pkg::EMIT_ZERO;
            end
         end
         b2d_pkg::EMIT_ZERO: begin
            if (adv) state_in = b2d_pkg::EMIT_IDLE;
         end
         default: state_in = b2d_pkg::EMIT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      bcd_ready = (state_ff == b2d_pkg::EMIT_IDLE);
      load      = bcd_valid && bcd_ready;
      adv       = (state_ff != b2d_pkg::EMIT_IDLE) && (!out_valid_ff || rsp_bus.ready);
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.digit   = out_digit_ff;
   assign rsp_bus.column  = out_col_ff;
   assign rsp_bus.out_row = out_row_ff;
   assign rsp_bus.last    = out_last_ff;

   always_comb begin
      digits_in    = digits_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      started_in   = started_ff;
      col_in       = col_ff;
      lastcol_in   = lastcol_ff;
      out_digit_in = out_digit_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (load) begin
         digits_in  = bcd_data;
         row_in     = bcd_row;
         pos_in     = '0;
         started_in = 1'b0;
         col_in     = '0;
      end else if (adv && state_ff == b2d_pkg::EMIT_RUN) begin
         out_valid_in = 1'b1;
         out_digit_in = started_now ? top_digit : b2d_pkg::BLANK_CODE;
         out_col_in   = col_use;
         out_row_in   = row_ff;
         out_last_in  = at_end && started_now;
         started_in   = started_now;
         lastcol_in   = col_use;
         col_in       = col_use + b2d_pkg::CELL_WIDTH;
         digits_in    = digits_ff << DW;
         pos_in       = pos_ff + POS_W'(1);
      end else if (adv) begin
         // all places blank: one more beat with a zero in the last cell
         out_valid_in = 1'b1;
         out_digit_in = b2d_pkg::ZERO_DIGIT;
         out_col_in   = lastcol_ff;
         out_row_in   = row_ff;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b2d_pkg::EMIT_IDLE;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff    <= digits_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      lastcol_ff   <= lastcol_in;
      out_digit_ff <= out_digit_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_last_ff  <= out_last_in;
   end

   `B2D_ASSERT(a_zero_only_unstarted, clock, reset, in_zero |-> !started_ff)
   `B2D_ASSERT(a_load_clears, clock, reset, load |=> (pos_ff == '0) && !started_ff)
   `B2D_ASSERT(a_zero_beat, clock, reset, (in_zero && adv) |=> zero_out)

endmodule

`default_nettype wire

### rtl/core/binary_to_decimal_digits_unit.sv
// top level of the binary to decimal digit unit: converter feeding the digit sequencer
// depends on b2d_pkg, b2d_req_if, b2d_rsp_if, b2d_convert and b2d_emit
//
//   channel   dir   beat contents
//   req_bus   in    value (27b), row (3b)
//   rsp_bus   out   digit (4b), column (7b), out_row (3b), last (1b)
//
// in the converter a value goes through one load, 27 shift and add-3 steps and one handoff
// the sequencer then gives one beat per cycle while rsp_bus is ready, DIGITS beats, or DIGITS+1 for a zero value
// conversion of the next value overlaps the beats of the previous one
// reset is synchronous and active high and clears all control state
// a stall on rsp_bus holds the output register and, once the converter is done, req_bus
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_digits_unit #(
   parameter int DIGITS = b2d_pkg::DIGITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   b2d_req_if.sink   req_bus,
   b2d_rsp_if.source rsp_bus
);

   logic                                  bcd_valid;
   logic                                  bcd_ready;
   logic [DIGITS*b2d_pkg::DIGIT_WIDTH-1:0] bcd_data;
   logic [b2d_pkg::ROW_WIDTH-1:0]         bcd_row;

   b2d_convert #(.DIGITS(DIGITS)) u_convert (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .bcd_valid (bcd_valid),
      .bcd_ready (bcd_ready),
      .bcd_data  (bcd_data),
      .bcd_row   (bcd_row)
   );

   b2d_emit #(.DIGITS(DIGITS)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .bcd_valid (bcd_valid),
      .bcd_ready (bcd_ready),
      .bcd_data  (bcd_data),
      .bcd_row   (bcd_row),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

### tb/sv/binary_to_decimal_digits_unit_tb.sv
// testbench of binary_to_decimal_digits_unit: directed table then random values, checked beat by
// beat against hand-typed cells or a digit predictor, the random values under several idle and stall patterns
// depends on b2d_pkg, b2d_req_if, b2d_rsp_if and the binary_to_decimal_digits_unit rtl
`timescale 1ns / 1ps

module binary_to_decimal_digits_unit_tb;
   import b2d_pkg::*;

   localparam int          DIGITS        = DIGITS_DEFAULT;
   localparam int unsigned MAX_VALUE     = 99_999_999;
   localparam int unsigned RAW_MAX       = (1 << VALUE_WIDTH) - 1;
   localparam int          RANDOM_ITEMS  = 100;
   localparam int          IDLE_LIMIT    = 2000;
   localparam int          DRAIN_CYCLES  = 60;
   localparam int          MAX_REPORTS   = 10;
   localparam int          TABLE_ROWS    = 22;

   typedef struct packed {
      logic [DIGIT_WIDTH-1:0]  digit;
      logic [COLUMN_WIDTH-1:0] column;
      logic [ROW_WIDTH-1:0]    out_row;
      logic                    last;
   } digit_beat_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [ROW_WIDTH-1:0]   row;
      logic                   typed;
      logic [3:0]             count;
      logic [35:0]            digits;
   } stim_row_type;

   localparam logic [COLUMN_WIDTH-1:0] CELL_COLUMN [9] = '{
      7'd0, 7'd10, 7'd22, 7'd32, 7'd42, 7'd54, 7'd64, 7'd74, 7'd74
   };

   localparam stim_row_type STIM_TABLE [TABLE_ROWS] = '{
      '{27'd0,         3'd0, 1'b1, 4'd9, 36'hA_AAAA_AAA0},
      '{27'd0,         3'd7, 1'b1, 4'd9, 36'hA_AAAA_AAA0},
      '{27'd1,         3'd1, 1'b1, 4'd8, 36'h0_AAAA_AAA1},
      '{27'd99999999,  3'd5, 1'b1, 4'd8, 36'h0_9999_9999},
      '{27'd100000000, 3'd2, 1'b1, 4'd8, 36'h0_9999_9999},
      '{27'h7FFFFFF,   3'd7, 1'b1, 4'd8, 36'h0_9999_9999},
      '{27'd10000000,  3'd3, 1'b1, 4'd8, 36'h0_1000_0000},
      '{27'd9,         3'd4, 1'b0, 4'd0, 36'h0},
      '{27'd10,        3'd6, 1'b0, 4'd0, 36'h0},
      '{27'd99,        3'd0, 1'b0, 4'd0, 36'h0},
      '{27'd100,       3'd1, 1'b0, 4'd0, 36'h0},
      '{27'd999,       3'd2, 1'b0, 4'd0, 36'h0},
      '{27'd1000,      3'd3, 1'b0, 4'd0, 36'h0},
      '{27'd99999,     3'd4, 1'b0, 4'd0, 36'h0},
      '{27'd100000,    3'd5, 1'b0, 4'd0, 36'h0},
      '{27'd1000000,   3'd6, 1'b0, 4'd0, 36'h0},
      '{27'd12345678,  3'd7, 1'b0, 4'd0, 36'h0},
      '{27'd98765432,  3'd0, 1'b0, 4'd0, 36'h0},
      '{27'd10101010,  3'd1, 1'b0, 4'd0, 36'h0},
      '{27'd90000009,  3'd2, 1'b0, 4'd0, 36'h0},
      '{27'd7,         3'd3, 1'b0, 4'd0, 36'h0},
      '{27'd100000001, 3'd4, 1'b0, 4'd0, 36'h0}
   };

   localparam int unsigned PLACE_WEIGHT [8] = '{
      10_000_000, 1_000_000, 100_000, 10_000, 1_000, 100, 10, 1
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   b2d_req_if req_bus ();
   b2d_rsp_if rsp_bus ();

   binary_to_decimal_digits_unit #(
      .DIGITS (DIGITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   digit_beat_type expected_cells [$];
   int             mismatch_count = 0;
   int             sender_idle_pct = 0;
   int             sink_stall_pct = 0;

   always #5 clock = ~clock;

   // digit cells for one value, most significant place first
   function automatic void predict_cells(input logic [VALUE_WIDTH-1:0] value,
                                         input logic [ROW_WIDTH-1:0] row);
      int unsigned             rest;
      int unsigned             count;
      logic [COLUMN_WIDTH-1:0] col;
      logic [COLUMN_WIDTH-1:0] last_col;
      bit                      started;
      digit_beat_type          beat;
      rest     = value;
      col      = '0;
      last_col = '0;
      started  = 1'b0;
      if (rest > MAX_VALUE) rest = MAX_VALUE;
      for (int p = 0; p < DIGITS; p++) begin
         count = 0;
         while (rest >= PLACE_WEIGHT[p]) begin
            rest  = rest - PLACE_WEIGHT[p];
            count = count + 1;
         end
         if (count != 0) started = 1'b1;
         if ((DIGITS - 1 - p) == GAP_PLACE_HI || (DIGITS - 1 - p) == GAP_PLACE_LO)
            col = col + GROUP_GAP;
         beat.digit   = started ? DIGIT_WIDTH'(count) : BLANK_CODE;
         beat.column  = col;
         beat.out_row = row;
         beat.last    = (p == DIGITS - 1) && started;
         expected_cells.push_back(beat);
         last_col = col;
         col      = col + CELL_WIDTH;
      end
      if (!started) begin
         beat.digit   = ZERO_DIGIT;
         beat.column  = last_col;
         beat.out_row = row;
         beat.last    = 1'b1;
         expected_cells.push_back(beat);
      end
   endfunction

   // hand-typed cells for the rows of the table that carry them
   function automatic void push_typed_cells(input stim_row_type r);
      digit_beat_type beat;
      for (int k = 0; k < r.count; k++) begin
         beat.digit   = r.digits[4*(r.count-1-k) +: 4];
         beat.column  = CELL_COLUMN[k];
         beat.out_row = r.row;
         beat.last    = (k == r.count - 1);
         expected_cells.push_back(beat);
      end
   endfunction

   function automatic void note_mismatch(input string what, input digit_beat_type exp_cell,
                                         input digit_beat_type got_cell);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $write("mismatch %s: expected digit %0d column %0d row %0d last %0d",
                what, exp_cell.digit, exp_cell.column, exp_cell.out_row, exp_cell.last);
         $display(", got digit %0d column %0d row %0d last %0d",
                  got_cell.digit, got_cell.column, got_cell.out_row, got_cell.last);
      end
   endfunction

   // one value per beat, with random gaps before it
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value,
                             input logic [ROW_WIDTH-1:0] row, input bit typed,
                             input stim_row_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.row   <= row;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (typed) push_typed_cells(r);
      else predict_cells(value, row);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      if (pick < 12) return VALUE_WIDTH'($urandom_range(MAX_VALUE + 1, RAW_MAX));
      if (pick < 20) return VALUE_WIDTH'($urandom);
      if (pick < 45)
         return VALUE_WIDTH'($urandom_range(0, PLACE_WEIGHT[$urandom_range(0, 6)] - 1));
      return VALUE_WIDTH'($urandom_range(0, MAX_VALUE));
   endfunction

   // result side: check each beat, then pick ready for the next cycle
   always @(posedge clock) begin
      digit_beat_type got_cell;
      digit_beat_type exp_cell;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_cell.digit   = rsp_bus.digit;
            got_cell.column  = rsp_bus.column;
            got_cell.out_row = rsp_bus.out_row;
            got_cell.last    = rsp_bus.last;
            if (expected_cells.size() == 0) begin
               note_mismatch("unexpected beat", '0, got_cell);
            end else begin
               exp_cell = expected_cells.pop_front();
               if (got_cell !== exp_cell) note_mismatch("on beat", exp_cell, got_cell);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout with %0d beats outstanding", expected_cells.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      stim_row_type no_row;
      no_row = '0;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.row   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TABLE_ROWS; i++)
         send_value(STIM_TABLE[i].value, STIM_TABLE[i].row, STIM_TABLE[i].typed,
                    STIM_TABLE[i]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 55; end
            default: begin sender_idle_pct = 35; sink_stall_pct = 35; end
         endcase
         for (int i = 0; i < RANDOM_ITEMS; i++)
            send_value(random_value(), ROW_WIDTH'($urandom_range(0, 7)), 1'b0, no_row);
      end
      req_bus.valid <= 1'b0;

      while (expected_cells.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/b2d_pkg.sv
rtl/core/b2d_req_if.sv
rtl/core/b2d_rsp_if.sv
rtl/core/b2d_convert.sv
rtl/core/b2d_emit.sv
rtl/core/binary_to_decimal_digits_unit.sv
tb/sv/binary_to_decimal_digits_unit_tb.sv
